// File: rtl/dfd_pkg.sv
// Shared types, constants and the divide-by-ten helper for the factorial digit unit.
package dfd_pkg;

    localparam int N_W      = 6;   // width of the request operand
    localparam int DIGIT_W  = 4;   // one decimal digit
    localparam int TOTAL_W  = 7;   // digit count as presented on the port
    localparam int CARRY_W  = 6;   // carry between digit positions
    localparam int PROD_W   = 10;  // digit * multiplier + carry

    localparam logic [DIGIT_W-1:0] RADIX     = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE = 4'd1;
    localparam logic [N_W-1:0]     MUL_START = 6'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ALIGN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RING_HOLD,
        RING_FWD,
        RING_REV,
        RING_LOAD
    } t_ring_op;

    typedef struct packed {
        t_ring_op            op;
        logic [DIGIT_W-1:0]  wr_digit;
    } t_ring_ctl;

    // Restoring division by ten: quotient in the upper bits, remainder in the lower four.
    function automatic logic [CARRY_W+DIGIT_W-1:0] div10(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0]  rem;
        logic [CARRY_W-1:0] quo;
        rem = p;
        quo = '0;
        for (int b = CARRY_W - 1; b >= 0; b--) begin
            if (rem >= (PROD_W'(RADIX) << b)) begin
                rem    = rem - (PROD_W'(RADIX) << b);
                quo[b] = 1'b1;
            end
        end
        return {quo, rem[DIGIT_W-1:0]};
    endfunction

endpackage

// File: rtl/dfd_digit_ring.sv
// Circular shift register holding the decimal digits, one digit moved per cycle unless held.
module dfd_digit_ring #(
    parameter int DIGITS = 64
) (
    input  logic                        i_clk,
    input  dfd_pkg::t_ring_ctl          i_ctl,
    output logic [dfd_pkg::DIGIT_W-1:0] o_head
);
    import dfd_pkg::*;

    logic [DIGIT_W-1:0] r_ring [DIGITS];
    logic [DIGIT_W-1:0] n_ring [DIGITS];

    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            n_ring[j] = r_ring[j];
        end
        case (i_ctl.op)
            RING_FWD: begin
                // head leaves, new digit enters at the tail
                for (int j = 0; j < DIGITS - 1; j++) begin
                    n_ring[j] = r_ring[j+1];
                end
                n_ring[DIGITS-1] = i_ctl.wr_digit;
            end
            RING_REV: begin
                for (int j = 1; j < DIGITS; j++) begin
                    n_ring[j] = r_ring[j-1];
                end
                n_ring[0] = r_ring[DIGITS-1];
            end
            RING_LOAD: begin
                n_ring[0] = DIGIT_ONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIGITS; j++) begin
            r_ring[j] <= n_ring[j];
        end
    end

    assign o_head = r_ring[0];

endmodule

// File: rtl/decimal_factorial_digits_unit.sv
// Top level: computes n! in decimal and streams its digits, most significant first.
//
// Request channel: i_valid / o_stall carry the operand i_n. A request is taken
// only while the unit is idle; o_stall stays high from acceptance until the
// final digit has been taken. Operands above MAX_N are clamped to MAX_N.
// Result channel: o_valid / i_stall carry one digit per transfer, with
// o_digit_total on every digit and o_last on the least significant one.
// Operation: for n of 2 or more, (n-1) multiply passes, each walking all DIGITS
// positions of the digit ring one digit per cycle through a single small
// multiply and divide-by-ten unit; then the ring is aligned so that the top
// digit is at the head, then digit_total transfers.
// Reset (synchronous, active low) returns the unit to idle with no result
// pending; the digit ring itself is not cleared.
// A stall on the result side holds the current digit and its flags unchanged
// and pauses the ring until the digit is taken.
module decimal_factorial_digits_unit #(
    parameter int DIGITS = 64,
    parameter int MAX_N  = 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dfd_pkg::N_W-1:0]      i_n,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dfd_pkg::DIGIT_W-1:0]  o_digit,
    output logic [dfd_pkg::TOTAL_W-1:0]  o_digit_total,
    output logic                         o_last
);
    import dfd_pkg::*;

    localparam int IW = $clog2(DIGITS);
    localparam int CW = $clog2(DIGITS + 1);

    t_state             r_state, n_state;
    logic [N_W-1:0]     r_n, n_n;
    logic [N_W-1:0]     r_mul, n_mul;
    logic [IW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_count, n_count;
    logic [CARRY_W-1:0] r_carry, n_carry;

    t_ring_ctl          w_ring_ctl;
    logic [DIGIT_W-1:0] w_head;
    logic [N_W-1:0]     w_n_sat;
    logic               w_in_range;
    logic [DIGIT_W-1:0] w_digit_in;
    logic [PROD_W-1:0]  w_prod;
    logic [CARRY_W+DIGIT_W-1:0] w_qr;
    logic               w_pass_end;
    logic               w_at_top;
    logic               w_take;

    dfd_digit_ring #(
        .DIGITS (DIGITS)
    ) u_ring (
        .i_clk  (i_clk),
        .i_ctl  (w_ring_ctl),
        .o_head (w_head)
    );

    assign w_n_sat    = (i_n > N_W'(MAX_N)) ? N_W'(MAX_N) : i_n;
    assign w_in_range = CW'(r_idx) < r_count;
    // positions past the current length count as zero, so the carry spills into them
    assign w_digit_in = w_in_range ? w_head : '0;
    assign w_prod     = PROD_W'(w_digit_in) * PROD_W'(r_mul) + PROD_W'(r_carry);
    assign w_qr       = div10(w_prod);
    assign w_pass_end = (r_idx == IW'(DIGITS - 1));
    assign w_at_top   = (CW'(r_idx) == r_count - CW'(1));
    assign w_take     = !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (w_n_sat >= MUL_START) ? ST_MUL : ST_ALIGN;
                end
            end
            ST_MUL: begin
                if (w_pass_end && r_mul == r_n) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (w_at_top) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_take && w_at_top) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and ring control
    always_comb begin
        o_stall             = 1'b1;
        o_valid             = 1'b0;
        w_ring_ctl.op       = RING_HOLD;
        w_ring_ctl.wr_digit = w_qr[DIGIT_W-1:0];
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    w_ring_ctl.op = RING_LOAD;
                end
            end
            ST_MUL: begin
                w_ring_ctl.op = RING_FWD;
            end
            ST_ALIGN: begin
                // bring the top digit to the head, recirculating each digit unchanged
                w_ring_ctl.wr_digit = w_head;
                if (!w_at_top) begin
                    w_ring_ctl.op = RING_FWD;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (w_take && !w_at_top) begin
                    w_ring_ctl.op = RING_REV;
                end
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_n     = r_n;
        n_mul   = r_mul;
        n_idx   = r_idx;
        n_count = r_count;
        n_carry = r_carry;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_n     = w_n_sat;
                    n_mul   = MUL_START;
                    n_idx   = '0;
                    n_count = CW'(1);
                    n_carry = '0;
                end
            end
            ST_MUL: begin
                n_carry = w_qr[CARRY_W+DIGIT_W-1:DIGIT_W];
                if (!w_in_range && r_carry != '0) begin
                    n_count = r_count + CW'(1);
                end
                if (w_pass_end) begin
                    // drop whatever carry does not fit
                    n_idx   = '0;
                    n_carry = '0;
                    n_mul   = r_mul + N_W'(1);
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_ALIGN: begin
                n_idx = w_at_top ? '0 : r_idx + IW'(1);
            end
            ST_EMIT: begin
                if (w_take && !w_at_top) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mul   <= MUL_START;
            r_idx   <= '0;
            r_count <= CW'(1);
            r_carry <= '0;
        end else begin
            r_state <= n_state;
            r_mul   <= n_mul;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
    end

    assign o_digit       = w_head;
    assign o_digit_total = TOTAL_W'(r_count);
    assign o_last        = w_at_top;

endmodule

// File: rtl/dfd_checker.sv
// Port-level checks for the factorial digit unit, bound to the top level.
module dfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_digit,
    input logic [6:0] o_digit_total,
    input logic       o_last
);

    // a stalled digit holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit) && $stable(o_digit_total)
            && $stable(o_last))
        else $error("stalled digit changed");

    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_digit <= 4'd9 && o_digit_total != 7'd0)
        else $error("digit or total out of range");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("digit run broken before last");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid && !o_stall)
        else $error("unit not idle after last digit");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while digits pending");

endmodule

bind decimal_factorial_digits_unit dfd_checker u_dfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digit       (o_digit),
    .o_digit_total (o_digit_total),
    .o_last        (o_last)
);

// File: tb/sv/factorial_digit_tracker_pkg.sv
// Digit predictor and result tracker for the factorial digit unit testbench.
`timescale 1ns / 100ps
package factorial_digit_tracker_pkg;

    import dfd_pkg::*;

    localparam int STORE_DIGITS = 64;
    localparam int TOP_N        = 49;
    localparam int DECIMAL_BASE = 10;

    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_digit_result;

    class factorial_digit_tracker;

        t_digit_result pending_digits[$];
        int unsigned   mismatches;
        int unsigned   digits_seen;
        int unsigned   requests_seen;

        function new();
            mismatches    = 0;
            digits_seen   = 0;
            requests_seen = 0;
        endfunction

        // Build n! digit by digit and queue its digits, most significant first.
        function void add_request(input logic [N_W-1:0] n);
            logic [DIGIT_W-1:0] store [STORE_DIGITS];
            int unsigned        count;
            int unsigned        carry;
            int unsigned        prod;
            int unsigned        limit;
            int unsigned        m;
            int unsigned        i;
            t_digit_result      res;
            foreach (store[j]) store[j] = '0;
            limit = (n > TOP_N) ? TOP_N : n;
            store[0] = 4'd1;
            count    = 1;
            for (m = 2; m <= limit; m++) begin
                carry = 0;
                for (i = 0; i < count; i++) begin
                    prod     = store[i] * m + carry;
                    store[i] = DIGIT_W'(prod % DECIMAL_BASE);
                    carry    = prod / DECIMAL_BASE;
                end
                // extend with the leftover carry; drop whatever no longer fits
                while (carry != 0 && count < STORE_DIGITS) begin
                    store[count] = DIGIT_W'(carry % DECIMAL_BASE);
                    carry        = carry / DECIMAL_BASE;
                    count++;
                end
            end
            for (i = count; i > 0; i--) begin
                res.digit = store[i-1];
                res.total = TOTAL_W'(count);
                res.last  = (i == 1);
                pending_digits.push_back(res);
            end
            requests_seen++;
        endfunction

        function void check_digit(input logic [DIGIT_W-1:0] digit,
                                  input logic [TOTAL_W-1:0] total,
                                  input logic               last);
            t_digit_result want;
            digits_seen++;
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit %0d (total %0d, last %0b)",
                         $time, digit, total, last);
                mismatches++;
                return;
            end
            want = pending_digits.pop_front();
            if (digit !== want.digit) begin
                $display("%0t: digit expected %0d, actual %0d", $time, want.digit, digit);
                mismatches++;
            end
            if (total !== want.total) begin
                $display("%0t: digit_total expected %0d, actual %0d",
                         $time, want.total, total);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_digits.size();
        endfunction

    endclass

endpackage

// File: tb/sv/decimal_factorial_digits_unit_tb.sv
// Testbench top for the factorial digit unit: drives requests, checks every digit.
`timescale 1ns / 100ps
module decimal_factorial_digits_unit_tb;

    import dfd_pkg::*;
    import factorial_digit_tracker_pkg::*;

    localparam int RANDOM_REQUESTS = 155;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [N_W-1:0]     i_n;
    logic               o_valid;
    logic               i_stall;
    logic [DIGIT_W-1:0] o_digit;
    logic [TOTAL_W-1:0] o_digit_total;
    logic               o_last;

    factorial_digit_tracker tracker;
    bit                     burst_mode = 1'b0;
    int unsigned            sink_hold  = 0;
    int unsigned            largest_n  = 0;
    int unsigned            above_range = 0;

    decimal_factorial_digits_unit #(
        .DIGITS (STORE_DIGITS),
        .MAX_N  (TOP_N)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_n           (i_n),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digit       (o_digit),
        .o_digit_total (o_digit_total),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request after a random gap, or none in burst mode, and hold it until taken.
    task automatic send_request(input logic [N_W-1:0] n);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_n     <= n;
        do @(posedge i_clk); while (o_stall);
        tracker.add_request(n);
        if (n > largest_n) largest_n = 32'(n);
        if (n > TOP_N) above_range++;
    endtask

    task automatic drain_results();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_digit(o_digit, o_digit_total, o_last);
    end

    // Result side: stall for a drawn or forced hold (none in burst mode), then take one digit.
    initial begin : result_sink
        int unsigned hold_cycles;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold != 0) begin
                hold_cycles = sink_hold;
                sink_hold   = 0;
            end else begin
                hold_cycles = burst_mode ? 0 : $urandom_range(0, 12);
            end
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : run_limit
        #50_000_000;
        $display("[decimal_factorial_digits_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned      directed_ns[$];
        int unsigned      pick;
        logic [N_W-1:0]   n;
        tracker = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_n     = '0;
        i_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero and one, first multiplies, trailing zeros, top of range, clamped values
        directed_ns = '{0, 1, 2, 3, 4, 5, 7, 9, 10, 13, 15, 16, 20, 24, 25, 31, 32,
                        33, 47, 48, 49, 50, 62, 63, 42};
        foreach (directed_ns[k])
            send_request(N_W'(directed_ns[k]));

        // pause until the unit has handed back everything
        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_results();

        for (int r = 0; r < RANDOM_REQUESTS; r++) begin
            if (r == 60)
                sink_hold = 400;
            burst_mode = (r >= 100 && r < 130);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n = N_W'($urandom_range(0, 20));
            else if (pick < 9)
                n = N_W'($urandom_range(0, TOP_N));
            else
                n = N_W'($urandom_range(TOP_N + 1, (1 << N_W) - 1));
            send_request(n);
        end
        burst_mode = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_results();
        repeat (2 * STORE_DIGITS) @(posedge i_clk);

        $display("Covered %0d requests, n up to %0d with %0d above range clamped,",
                 tracker.requests_seen, largest_n, above_range);
        $display("and %0d digits checked under random and held result stalls.",
                 tracker.digits_seen);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("[decimal_factorial_digits_unit] OK");
        else
            $display("[decimal_factorial_digits_unit] ERROR");
        $finish;
    end

endmodule
